>>> design/text_console_escape_engine_defines.svh
// ----------------------------------------------------------------------------
// Text console escape engine assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_ESCAPE_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_ESCAPE_ENGINE_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define TCE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tce check failed");

// Check that a condition implies another in the next cycle.
`define TCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tce check failed");

`endif

>>> design/tce_pkg.sv
// ----------------------------------------------------------------------------
// Text console escape engine package
// Widths, character codes, command codes and the controller types.
// ----------------------------------------------------------------------------
`default_nettype none

package tce_pkg;

    // Geometry defaults
    localparam int TCE_MAX_COLS = 256;
    localparam int TCE_MAX_ROWS = 128;

    // Field widths
    localparam int CH_W    = 8;
    localparam int OP_W    = 2;
    localparam int ROW_W   = 7;
    localparam int COL_W   = 8;
    localparam int CUR_W   = 16;
    localparam int PARAM_W = 16;
    localparam int CFG_IW  = 2;
    localparam int CFG_DW  = 9;
    localparam int CCFG_W  = 9;
    localparam int RCFG_W  = 8;

    // Configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_ENABLE = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_COLS   = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_ROWS   = 2'd2;

    localparam logic [CCFG_W-1:0] COLS_RST = 9'd80;
    localparam logic [RCFG_W-1:0] ROWS_RST = 8'd25;

    // Result operation codes
    localparam logic [OP_W-1:0] OP_DRAW   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
    localparam logic [OP_W-1:0] OP_SCROLL = 2'd2;

    // Character codes
    localparam logic [CH_W-1:0] CH_ESC   = 8'h1B;
    localparam logic [CH_W-1:0] CH_LBR   = 8'h5B;
    localparam logic [CH_W-1:0] CH_J     = 8'h4A;
    localparam logic [CH_W-1:0] CH_H     = 8'h48;
    localparam logic [CH_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [CH_W-1:0] CH_NL    = 8'h0A;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CH_W-1:0] CH_BS    = 8'h08;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_0     = 8'h30;
    localparam logic [CH_W-1:0] CH_9     = 8'h39;

    localparam logic [PARAM_W-1:0] PARAM_MAX = 16'hFFFF;
    localparam int DEC_BASE = 10;

    typedef enum logic [1:0] {PM_NORMAL, PM_ESC, PM_CSI} t_pmode;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_DECODE, S_DRAW, S_SCROLL, S_SCR_RD, S_SCR_WR,
        S_FILL, S_CLEAR, S_HCHK, S_EM_MARK, S_RD_CUR, S_EM_CUR
    } t_state;

    typedef enum logic [3:0] {
        BC_OTHER, BC_ESC, BC_LBR, BC_DIGIT, BC_SEMI, BC_J, BC_H, BC_NL, BC_CR, BC_BS
    } t_bcls;

    typedef enum logic [2:0] {
        CO_NONE, CO_HOME, CO_PLACE, CO_CR, CO_BS, CO_ADV, CO_NL
    } t_curop;

    typedef enum logic [1:0] {MK_NONE, MK_SET, MK_DROP} t_mkop;
    typedef enum logic [2:0] {ES_CHAR, ES_MARK, ES_CUR, ES_CLEAR, ES_SCROLL} t_esrc;
    typedef enum logic [1:0] {RS_MARK, RS_CUR, RS_SCR} t_rsel;
    typedef enum logic [1:0] {WS_NONE, WS_CHAR, WS_SPACE, WS_COPY} t_wsel;
    typedef enum logic [2:0] {WK_NONE, WK_ZERO, WK_LASTROW, WK_STEP, WK_ALL} t_wkop;

    // Commands from controller to datapath
    typedef struct packed {
        logic   load_ch;
        logic   p_clear;
        logic   p_digit;
        logic   p_semi;
        t_curop cur_op;
        t_mkop  mk_op;
        logic   emit;
        t_esrc  esrc;
        logic   elast;
        t_rsel  rsel;
        t_wsel  wsel;
        t_wkop  wk_op;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic  en;
        t_bcls cls;
        logic  cur_on;
        logic  mark_on;
        logic  wrap_col;
        logic  wrap_row;
        logic  out_free;
        logic  one_row;
        logic  copy_end;
        logic  fill_end;
        logic  all_end;
    } t_stat;

endpackage

`default_nettype wire

>>> design/tce_byte_if.sv
// ----------------------------------------------------------------------------
// Text console input channel
// Valid/ready channel carrying one text byte per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface tce_byte_if;
    import tce_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink (input valid, input ch, output ready);
endinterface

`default_nettype wire

>>> design/tce_cell_if.sv
// ----------------------------------------------------------------------------
// Text console result channel
// Valid/ready channel carrying one draw, clear or scroll command per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface tce_cell_if;
    import tce_pkg::*;

    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [ROW_W-1:0] cell_row;
    logic [COL_W-1:0] cell_col;
    logic [CH_W-1:0]  glyph_code;
    logic             inverted;
    logic             last;

    modport source (output valid, output op, output cell_row, output cell_col,
                    output glyph_code, output inverted, output last, input ready);
    modport sink (input valid, input op, input cell_row, input cell_col,
                  input glyph_code, input inverted, input last, output ready);
endinterface

`default_nettype wire

>>> design/tce_datapath.sv
// ----------------------------------------------------------------------------
// Text console datapath
// Character store, cursor, marker, CSI parameters, walk counters and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tce_datapath #(
    parameter int MAX_COLS = tce_pkg::TCE_MAX_COLS,
    parameter int MAX_ROWS = tce_pkg::TCE_MAX_ROWS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [tce_pkg::CFG_IW-1:0]  i_cfg_idx,
    input  wire logic [tce_pkg::CFG_DW-1:0]  i_cfg_data,
    input  wire logic [tce_pkg::CH_W-1:0]    i_ch,
    input  wire tce_pkg::t_cmd               i_cmd,
    output tce_pkg::t_stat                   o_stat,
    input  wire logic                        i_out_ready,
    output logic                             o_out_valid,
    output logic [tce_pkg::OP_W-1:0]         o_op,
    output logic [tce_pkg::ROW_W-1:0]        o_cell_row,
    output logic [tce_pkg::COL_W-1:0]        o_cell_col,
    output logic [tce_pkg::CH_W-1:0]         o_glyph_code,
    output logic                             o_inverted,
    output logic                             o_last
);
    import tce_pkg::*;

    localparam int RW  = $clog2(MAX_ROWS);
    localparam int CW  = $clog2(MAX_COLS);
    localparam int RW1 = $clog2(MAX_ROWS + 1);
    localparam int CW1 = $clog2(MAX_COLS + 1);
    localparam int RWX = RW1 + 1;
    localparam int AW  = RW + CW;
    localparam int DEPTH = 1 << AW;

    // Configuration
    logic              r_en;
    logic [CCFG_W-1:0] r_cfg_cols;
    logic [RCFG_W-1:0] r_cfg_rows;

    // Parser, cursor and marker
    logic [CH_W-1:0]    r_ch;
    logic [1:0]         r_pcnt, n_pcnt;
    logic [PARAM_W-1:0] r_p0, r_p1, n_p0, n_p1;
    logic [CUR_W-1:0]   r_crow, r_ccol, n_crow, n_ccol;
    logic               r_mvalid, n_mvalid;
    logic [ROW_W-1:0]   r_mrow, n_mrow;
    logic [COL_W-1:0]   r_mcol, n_mcol;

    // Walk counters
    logic [RW-1:0] r_wrow, n_wrow;
    logic [CW-1:0] r_wcol, n_wcol;

    // Store
    logic [CH_W-1:0] r_mem [DEPTH];
    logic [CH_W-1:0] r_rdata;
    logic [AW-1:0]   raddr, waddr;
    logic [CH_W-1:0] wdata;
    logic            we;

    // Result register
    logic             r_ovalid;
    logic [OP_W-1:0]  r_op;
    logic [ROW_W-1:0] r_orow;
    logic [COL_W-1:0] r_ocol;
    logic [CH_W-1:0]  r_oglyph;
    logic             r_oinv;
    logic             r_olast;

    logic [RW1-1:0]   ur;
    logic [CW1-1:0]   uc;
    logic [CUR_W:0]   crow_inc, ccol_inc;
    logic [CUR_W-1:0] wrap_row_val;
    logic             out_free;
    logic             walk_col_end;
    logic             walk_row_end;
    logic [19:0]      dig_sum;
    logic [PARAM_W-1:0] dig_sat, dig_base;
    logic [PARAM_W-1:0] place_row, place_col;
    logic [AW-1:0]    cur_addr, mark_addr, walk_addr, scr_addr;
    t_bcls            cls;

    // Clamp the geometry in use
    always_comb begin
        if (r_cfg_rows == '0) begin
            ur = RW1'(1);
        end else if (32'(r_cfg_rows) > MAX_ROWS) begin
            ur = RW1'(MAX_ROWS);
        end else begin
            ur = RW1'(r_cfg_rows);
        end
        if (r_cfg_cols == '0) begin
            uc = CW1'(1);
        end else if (32'(r_cfg_cols) > MAX_COLS) begin
            uc = CW1'(MAX_COLS);
        end else begin
            uc = CW1'(r_cfg_cols);
        end
    end

    // Classify the held byte
    always_comb begin
        if (r_ch == CH_ESC) begin
            cls = BC_ESC;
        end else if (r_ch == CH_LBR) begin
            cls = BC_LBR;
        end else if (r_ch >= CH_0 && r_ch <= CH_9) begin
            cls = BC_DIGIT;
        end else if (r_ch == CH_SEMI) begin
            cls = BC_SEMI;
        end else if (r_ch == CH_J) begin
            cls = BC_J;
        end else if (r_ch == CH_H) begin
            cls = BC_H;
        end else if (r_ch == CH_NL) begin
            cls = BC_NL;
        end else if (r_ch == CH_CR) begin
            cls = BC_CR;
        end else if (r_ch == CH_BS) begin
            cls = BC_BS;
        end else begin
            cls = BC_OTHER;
        end
    end

    assign crow_inc     = {1'b0, r_crow} + (CUR_W + 1)'(1);
    assign ccol_inc     = {1'b0, r_ccol} + (CUR_W + 1)'(1);
    assign out_free     = !r_ovalid || i_out_ready;
    assign walk_col_end = (CW1'(r_wcol) == uc - CW1'(1));
    assign walk_row_end = (RW1'(r_wrow) == ur - RW1'(1));
    // Next row, held on the last row in use
    assign wrap_row_val = (crow_inc >= (CUR_W + 1)'(ur)) ? CUR_W'(ur - RW1'(1))
                                                          : crow_inc[CUR_W-1:0];

    // Status toward the controller
    always_comb begin
        o_stat.en       = r_en;
        o_stat.cls      = cls;
        o_stat.cur_on   = (r_crow < CUR_W'(ur)) && (r_ccol < CUR_W'(uc));
        o_stat.mark_on  = r_mvalid && (CUR_W'(r_mrow) < CUR_W'(ur))
                          && (CUR_W'(r_mcol) < CUR_W'(uc));
        o_stat.wrap_col = (ccol_inc >= (CUR_W + 1)'(uc));
        o_stat.wrap_row = (crow_inc >= (CUR_W + 1)'(ur));
        o_stat.out_free = out_free;
        o_stat.one_row  = (ur == RW1'(1));
        o_stat.copy_end = walk_col_end && (RWX'(r_wrow) + RWX'(2) == RWX'(ur));
        o_stat.fill_end = walk_col_end && walk_row_end;
        o_stat.all_end  = (&r_wrow) && (&r_wcol);
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en       <= 1'b0;
            r_cfg_cols <= COLS_RST;
            r_cfg_rows <= ROWS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLE: r_en       <= i_cfg_data[0];
                CFG_COLS:   r_cfg_cols <= i_cfg_data[CCFG_W-1:0];
                CFG_ROWS:   r_cfg_rows <= i_cfg_data[RCFG_W-1:0];
                default:    ;
            endcase
        end
    end

    // Hold the accepted byte
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_ch) begin
            r_ch <= i_ch;
        end
    end

    // Accumulate CSI parameters, saturating
    assign dig_base = (r_pcnt >= 2'd2) ? r_p1 : r_p0;
    assign dig_sum  = 20'(dig_base) * 20'(DEC_BASE) + 20'(r_ch - CH_0);
    assign dig_sat  = (dig_sum > 20'(PARAM_MAX)) ? PARAM_MAX : dig_sum[PARAM_W-1:0];

    always_comb begin
        n_pcnt = r_pcnt;
        n_p0   = r_p0;
        n_p1   = r_p1;
        if (i_cmd.p_clear) begin
            n_pcnt = 2'd0;
            n_p0   = '0;
            n_p1   = '0;
        end else if (i_cmd.p_digit) begin
            if (r_pcnt == 2'd0) begin
                n_pcnt = 2'd1;
            end
            if (r_pcnt >= 2'd2) begin
                n_p1 = dig_sat;
            end else begin
                n_p0 = dig_sat;
            end
        end else if (i_cmd.p_semi) begin
            n_pcnt = 2'd2;
        end
    end

    // Cursor placement from parameters, zero or missing meaning one
    assign place_row = ((r_pcnt >= 2'd1) && (r_p0 != '0)) ? r_p0 - PARAM_W'(1) : '0;
    assign place_col = ((r_pcnt >= 2'd2) && (r_p1 != '0)) ? r_p1 - PARAM_W'(1) : '0;

    // Move the cursor
    always_comb begin
        n_crow = r_crow;
        n_ccol = r_ccol;
        case (i_cmd.cur_op)
            CO_HOME: begin
                n_crow = '0;
                n_ccol = '0;
            end
            CO_PLACE: begin
                n_crow = place_row;
                n_ccol = place_col;
            end
            CO_CR: begin
                n_ccol = '0;
            end
            CO_BS: begin
                if (r_ccol != '0) begin
                    n_ccol = r_ccol - CUR_W'(1);
                end
            end
            CO_ADV: begin
                if (o_stat.wrap_col) begin
                    n_ccol = '0;
                    n_crow = wrap_row_val;
                end else begin
                    n_ccol = ccol_inc[CUR_W-1:0];
                end
            end
            CO_NL: begin
                n_ccol = '0;
                n_crow = wrap_row_val;
            end
            default: ;
        endcase
    end

    // Set or drop the indicator cell
    always_comb begin
        n_mvalid = r_mvalid;
        n_mrow   = r_mrow;
        n_mcol   = r_mcol;
        case (i_cmd.mk_op)
            MK_SET: begin
                n_mvalid = 1'b1;
                n_mrow   = ROW_W'(r_crow);
                n_mcol   = COL_W'(r_ccol);
            end
            MK_DROP: begin
                n_mvalid = 1'b0;
                n_mrow   = '0;
                n_mcol   = '0;
            end
            default: ;
        endcase
    end

    // Advance the walk counters
    always_comb begin
        n_wrow = r_wrow;
        n_wcol = r_wcol;
        case (i_cmd.wk_op)
            WK_ZERO: begin
                n_wrow = '0;
                n_wcol = '0;
            end
            WK_LASTROW: begin
                n_wrow = RW'(ur - RW1'(1));
                n_wcol = '0;
            end
            WK_STEP: begin
                if (walk_col_end) begin
                    n_wcol = '0;
                    n_wrow = r_wrow + RW'(1);
                end else begin
                    n_wcol = r_wcol + CW'(1);
                end
            end
            WK_ALL: begin
                {n_wrow, n_wcol} = {r_wrow, r_wcol} + AW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcnt   <= 2'd0;
            r_p0     <= '0;
            r_p1     <= '0;
            r_crow   <= '0;
            r_ccol   <= '0;
            r_mvalid <= 1'b0;
            r_mrow   <= '0;
            r_mcol   <= '0;
            r_wrow   <= '0;
            r_wcol   <= '0;
        end else begin
            r_pcnt   <= n_pcnt;
            r_p0     <= n_p0;
            r_p1     <= n_p1;
            r_crow   <= n_crow;
            r_ccol   <= n_ccol;
            r_mvalid <= n_mvalid;
            r_mrow   <= n_mrow;
            r_mcol   <= n_mcol;
            r_wrow   <= n_wrow;
            r_wcol   <= n_wcol;
        end
    end

    // Store addresses and write data
    assign cur_addr  = {RW'(r_crow), CW'(r_ccol)};
    assign mark_addr = {RW'(r_mrow), CW'(r_mcol)};
    assign walk_addr = {r_wrow, r_wcol};
    assign scr_addr  = {r_wrow + RW'(1), r_wcol};

    always_comb begin
        case (i_cmd.rsel)
            RS_MARK: raddr = mark_addr;
            RS_CUR:  raddr = cur_addr;
            RS_SCR:  raddr = scr_addr;
            default: raddr = cur_addr;
        endcase
        we    = 1'b1;
        waddr = walk_addr;
        wdata = CH_SPACE;
        case (i_cmd.wsel)
            WS_CHAR: begin
                waddr = cur_addr;
                wdata = r_ch;
            end
            WS_SPACE: wdata = CH_SPACE;
            WS_COPY:  wdata = r_rdata;
            default:  we = 1'b0;
        endcase
    end

    // Character store, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[raddr];
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_olast <= i_cmd.elast;
            case (i_cmd.esrc)
                ES_CHAR: begin
                    r_op     <= OP_DRAW;
                    r_orow   <= ROW_W'(r_crow);
                    r_ocol   <= COL_W'(r_ccol);
                    r_oglyph <= r_ch;
                    r_oinv   <= 1'b0;
                end
                ES_MARK: begin
                    r_op     <= OP_DRAW;
                    r_orow   <= r_mrow;
                    r_ocol   <= r_mcol;
                    r_oglyph <= r_rdata;
                    r_oinv   <= 1'b0;
                end
                ES_CUR: begin
                    r_op     <= OP_DRAW;
                    r_orow   <= ROW_W'(r_crow);
                    r_ocol   <= COL_W'(r_ccol);
                    r_oglyph <= r_rdata;
                    r_oinv   <= 1'b1;
                end
                ES_CLEAR: begin
                    r_op     <= OP_CLEAR;
                    r_orow   <= '0;
                    r_ocol   <= '0;
                    r_oglyph <= '0;
                    r_oinv   <= 1'b0;
                end
                default: begin
                    r_op     <= OP_SCROLL;
                    r_orow   <= '0;
                    r_ocol   <= '0;
                    r_oglyph <= '0;
                    r_oinv   <= 1'b0;
                end
            endcase
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_op         = r_op;
    assign o_cell_row   = r_orow;
    assign o_cell_col   = r_ocol;
    assign o_glyph_code = r_oglyph;
    assign o_inverted   = r_oinv;
    assign o_last       = r_olast;

endmodule

`default_nettype wire

>>> design/tce_ctrl.sv
// ----------------------------------------------------------------------------
// Text console controller
// Escape parser mode and the sequencer for draws, clears, scrolls and the
// clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module tce_ctrl (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire tce_pkg::t_stat i_stat,
    output tce_pkg::t_cmd  o_cmd
);
    import tce_pkg::*;

    t_state r_state, n_state;
    t_pmode r_mode, n_mode;
    logic   adv_scroll;

    assign adv_scroll = i_stat.wrap_col && i_stat.wrap_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_mode  <= PM_NORMAL;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
        end
    end

    // Next state and parser mode
    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        case (r_state)
            S_INIT: begin
                if (i_stat.all_end) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                n_state = S_IDLE;
                if (i_stat.en) begin
                    case (r_mode)
                        PM_NORMAL: begin
                            case (i_stat.cls)
                                BC_ESC: n_mode = PM_ESC;
                                BC_NL: begin
                                    if (i_stat.wrap_row) n_state = S_SCROLL;
                                end
                                BC_CR, BC_BS: ;
                                default: begin
                                    if (i_stat.cur_on) begin
                                        n_state = S_DRAW;
                                    end else if (adv_scroll) begin
                                        n_state = S_SCROLL;
                                    end
                                end
                            endcase
                        end
                        PM_ESC: begin
                            n_mode = (i_stat.cls == BC_LBR) ? PM_CSI : PM_NORMAL;
                        end
                        default: begin
                            if (i_stat.cls != BC_DIGIT && i_stat.cls != BC_SEMI) begin
                                n_mode = PM_NORMAL;
                                if (i_stat.cls == BC_J) n_state = S_CLEAR;
                                if (i_stat.cls == BC_H) n_state = S_HCHK;
                            end
                        end
                    endcase
                end
            end
            S_DRAW: begin
                if (i_stat.out_free) n_state = adv_scroll ? S_SCROLL : S_IDLE;
            end
            S_SCROLL: begin
                if (i_stat.out_free) n_state = i_stat.one_row ? S_FILL : S_SCR_RD;
            end
            S_SCR_RD: n_state = S_SCR_WR;
            S_SCR_WR: n_state = i_stat.copy_end ? S_FILL : S_SCR_RD;
            S_FILL: begin
                if (i_stat.fill_end) n_state = S_IDLE;
            end
            S_CLEAR: begin
                if (i_stat.out_free) n_state = S_FILL;
            end
            S_HCHK: begin
                if (i_stat.mark_on) begin
                    n_state = S_EM_MARK;
                end else if (i_stat.cur_on) begin
                    n_state = S_EM_CUR;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EM_MARK: begin
                if (i_stat.out_free) n_state = i_stat.cur_on ? S_RD_CUR : S_IDLE;
            end
            S_RD_CUR: n_state = S_EM_CUR;
            S_EM_CUR: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands toward the datapath
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_INIT: begin
                o_cmd.wsel  = WS_SPACE;
                o_cmd.wk_op = WK_ALL;
            end
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_ch = 1'b1;
            end
            S_DECODE: begin
                if (i_stat.en) begin
                    case (r_mode)
                        PM_NORMAL: begin
                            case (i_stat.cls)
                                BC_ESC: ;
                                BC_NL:  o_cmd.cur_op = CO_NL;
                                BC_CR:  o_cmd.cur_op = CO_CR;
                                BC_BS:  o_cmd.cur_op = CO_BS;
                                default: begin
                                    if (!i_stat.cur_on) o_cmd.cur_op = CO_ADV;
                                end
                            endcase
                        end
                        PM_ESC: begin
                            if (i_stat.cls == BC_LBR) o_cmd.p_clear = 1'b1;
                        end
                        default: begin
                            case (i_stat.cls)
                                BC_DIGIT: o_cmd.p_digit = 1'b1;
                                BC_SEMI:  o_cmd.p_semi  = 1'b1;
                                BC_J: begin
                                    o_cmd.cur_op = CO_HOME;
                                    o_cmd.mk_op  = MK_DROP;
                                end
                                BC_H:    o_cmd.cur_op = CO_PLACE;
                                default: ;
                            endcase
                        end
                    endcase
                end
            end
            S_DRAW: begin
                if (i_stat.out_free) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.esrc   = ES_CHAR;
                    o_cmd.elast  = !adv_scroll;
                    o_cmd.wsel   = WS_CHAR;
                    o_cmd.cur_op = CO_ADV;
                end
            end
            S_SCROLL: begin
                if (i_stat.out_free) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.esrc  = ES_SCROLL;
                    o_cmd.elast = 1'b1;
                    o_cmd.wk_op = i_stat.one_row ? WK_LASTROW : WK_ZERO;
                end
            end
            S_SCR_RD: begin
                o_cmd.rsel = RS_SCR;
            end
            S_SCR_WR: begin
                o_cmd.rsel  = RS_SCR;
                o_cmd.wsel  = WS_COPY;
                o_cmd.wk_op = i_stat.copy_end ? WK_LASTROW : WK_STEP;
            end
            S_FILL: begin
                o_cmd.wsel  = WS_SPACE;
                o_cmd.wk_op = WK_STEP;
            end
            S_CLEAR: begin
                if (i_stat.out_free) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.esrc  = ES_CLEAR;
                    o_cmd.elast = 1'b1;
                    o_cmd.wk_op = WK_ZERO;
                end
            end
            S_HCHK: begin
                o_cmd.rsel = i_stat.mark_on ? RS_MARK : RS_CUR;
                if (!i_stat.mark_on && !i_stat.cur_on) o_cmd.mk_op = MK_DROP;
            end
            S_EM_MARK: begin
                o_cmd.rsel = RS_MARK;
                if (i_stat.out_free) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.esrc  = ES_MARK;
                    o_cmd.elast = !i_stat.cur_on;
                    if (!i_stat.cur_on) o_cmd.mk_op = MK_DROP;
                end
            end
            S_RD_CUR: begin
                o_cmd.rsel = RS_CUR;
            end
            S_EM_CUR: begin
                o_cmd.rsel = RS_CUR;
                if (i_stat.out_free) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.esrc  = ES_CUR;
                    o_cmd.elast = 1'b1;
                    o_cmd.mk_op = MK_SET;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

>>> design/text_console_escape_engine.sv
// ----------------------------------------------------------------------------
// Text console escape engine
// Byte-driven text console with a CSI escape parser and a character store.
//
//   channel  dir  word                                        handshake
//   i_byte   in   ch                                          valid/ready
//   o_cell   out  op, cell_row, cell_col, glyph_code,         valid/ready
//                 inverted, last
//   cfg      in   i_cfg_idx, i_cfg_data                       i_cfg_we
//
// A byte is accepted and then decoded; a drawn cell adds a draw state, and a
// cursor placement a check state and indicator results on the single read port.
// Scroll copies rows up, alternating store reads and writes, then fills the last
// row with spaces; clear fills the rows in use, one store write a cycle.
// After reset a clearing pass over all 2^(clog2(MAX_ROWS)+clog2(MAX_COLS)) cells
// (32768 at defaults) fills the store with spaces; no byte is taken meanwhile.
// A stalled result stalls the sequencer; configuration writes are always taken.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_escape_engine #(
    parameter int MAX_COLS = tce_pkg::TCE_MAX_COLS,
    parameter int MAX_ROWS = tce_pkg::TCE_MAX_ROWS
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [tce_pkg::CFG_IW-1:0] i_cfg_idx,
    input  wire logic [tce_pkg::CFG_DW-1:0] i_cfg_data,
    tce_byte_if.sink                        i_byte,
    tce_cell_if.source                      o_cell
);
    import tce_pkg::*;

    `include "text_console_escape_engine_defines.svh"

    t_cmd  cmd;
    t_stat stat;

    // Sequencer
    tce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_byte.valid),
        .o_in_ready (i_byte.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Store, cursor and result register
    tce_datapath #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_ch         (i_byte.ch),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_out_ready  (o_cell.ready),
        .o_out_valid  (o_cell.valid),
        .o_op         (o_cell.op),
        .o_cell_row   (o_cell.cell_row),
        .o_cell_col   (o_cell.cell_col),
        .o_glyph_code (o_cell.glyph_code),
        .o_inverted   (o_cell.inverted),
        .o_last       (o_cell.last)
    );

    // Checks
    `TCE_ASSERT_NEXT(a_no_back_to_back, i_clk, i_rst_n, i_byte.valid && i_byte.ready, !i_byte.ready)
    `TCE_ASSERT_SAME(a_cmd_zero_fields, i_clk, i_rst_n, o_cell.valid && (o_cell.op != OP_DRAW), (o_cell.cell_row == '0) && (o_cell.cell_col == '0) && (o_cell.glyph_code == '0) && !o_cell.inverted)
    `TCE_ASSERT_SAME(a_indicator_last, i_clk, i_rst_n, o_cell.valid && o_cell.inverted, o_cell.last)
    `TCE_ASSERT_SAME(a_scroll_last, i_clk, i_rst_n, o_cell.valid && (o_cell.op == OP_SCROLL), o_cell.last)

endmodule

`default_nettype wire

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// Text console escape engine testbench
// Feeds text, control bytes and CSI sequences through the byte channel under
// several screen geometries. Predicts every draw, clear and scroll command
// from a private copy of the console state and checks the result channel
// word by word. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import tce_pkg::*;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [CH_W-1:0]  glyph;
        logic             inv;
        logic             last;
    } t_cmd_word;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IW-1:0] i_cfg_idx;
    logic [CFG_DW-1:0] i_cfg_data;

    tce_byte_if bif ();
    tce_cell_if cif ();

    text_console_escape_engine i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_byte     (bif.sink),
        .o_cell     (cif.source)
    );

    // Console copy
    logic               con_en;
    logic [CCFG_W-1:0]  con_cols;
    logic [RCFG_W-1:0]  con_rows;
    t_pmode             pmode;
    int                 pcount;
    int                 pval [2];
    int                 cur_row, cur_col;
    logic               mk_valid;
    int                 mk_row, mk_col;
    logic [CH_W-1:0]    screen [TCE_MAX_ROWS*TCE_MAX_COLS];

    logic [CH_W-1:0] pending_bytes [$];
    t_cmd_word       expected_cmds [$];
    t_cmd_word       byte_cmds [$];
    int              n_errors;
    int              n_taken;
    logic            byte_taken;
    logic            steady;

    // Clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Run limit
    initial begin
        #(8 * 20_000_000);
        $display("Some tests failed");
        $finish;
    end

    function automatic int ucols();
        if (con_cols < 1) return 1;
        if (con_cols > TCE_MAX_COLS) return TCE_MAX_COLS;
        return con_cols;
    endfunction

    function automatic int urows();
        if (con_rows < 1) return 1;
        if (con_rows > TCE_MAX_ROWS) return TCE_MAX_ROWS;
        return con_rows;
    endfunction

    task automatic add_cmd(logic [OP_W-1:0] op, int row, int col, int glyph, logic inv);
        t_cmd_word w;
        w.op = op;
        w.row = row[ROW_W-1:0];
        w.col = col[COL_W-1:0];
        w.glyph = glyph[CH_W-1:0];
        w.inv = inv;
        w.last = 1'b0;
        byte_cmds.push_back(w);
    endtask

    task automatic scroll_screen();
        int rows, cols;
        rows = urows();
        cols = ucols();
        for (int r = 0; r + 1 < rows; r++)
            for (int c = 0; c < cols; c++)
                screen[r*TCE_MAX_COLS + c] = screen[(r+1)*TCE_MAX_COLS + c];
        for (int c = 0; c < cols; c++) screen[(rows-1)*TCE_MAX_COLS + c] = CH_SPACE;
        add_cmd(OP_SCROLL, 0, 0, 0, 1'b0);
    endtask

    task automatic line_feed();
        cur_col = 0;
        cur_row++;
        if (cur_row >= urows()) begin
            scroll_screen();
            cur_row = urows() - 1;
        end
    endtask

    task automatic place_cursor();
        int rows, cols, row, col;
        rows = urows();
        cols = ucols();
        row = (pcount >= 1 && pval[0] > 0) ? pval[0] : 1;
        col = (pcount >= 2 && pval[1] > 0) ? pval[1] : 1;
        cur_row = row - 1;
        cur_col = col - 1;
        // restore the old indicator cell if still on screen
        if (mk_valid && mk_row < rows && mk_col < cols)
            add_cmd(OP_DRAW, mk_row, mk_col, screen[mk_row*TCE_MAX_COLS + mk_col], 1'b0);
        if (cur_row < rows && cur_col < cols) begin
            add_cmd(OP_DRAW, cur_row, cur_col, screen[cur_row*TCE_MAX_COLS + cur_col], 1'b1);
            mk_valid = 1'b1;
            mk_row = cur_row & 8'h7F;
            mk_col = cur_col & 8'hFF;
        end else begin
            mk_valid = 1'b0;
            mk_row = 0;
            mk_col = 0;
        end
    endtask

    // Work out the commands one byte causes and queue them
    task automatic console_step(logic [CH_W-1:0] c);
        int v, idx;
        byte_cmds.delete();
        if (!con_en) return;
        case (pmode)
            PM_NORMAL: begin
                if (c == CH_ESC) pmode = PM_ESC;
                else if (c == CH_NL) line_feed();
                else if (c == CH_CR) cur_col = 0;
                else if (c == CH_BS) begin
                    if (cur_col > 0) cur_col--;
                end else begin
                    if (cur_row < urows() && cur_col < ucols()) begin
                        screen[cur_row*TCE_MAX_COLS + cur_col] = c;
                        add_cmd(OP_DRAW, cur_row, cur_col, c, 1'b0);
                    end
                    cur_col++;
                    if (cur_col >= ucols()) line_feed();
                end
            end
            PM_ESC: begin
                if (c == CH_LBR) begin
                    pmode = PM_CSI;
                    pcount = 0;
                    pval[0] = 0;
                    pval[1] = 0;
                end else pmode = PM_NORMAL;
            end
            default: begin
                if (c >= CH_0 && c <= CH_9) begin
                    if (pcount == 0) pcount = 1;
                    idx = (pcount >= 2) ? 1 : 0;
                    v = pval[idx] * DEC_BASE + (c - CH_0);
                    pval[idx] = (v > PARAM_MAX) ? PARAM_MAX : v;
                end else if (c == CH_SEMI) pcount = 2;
                else begin
                    if (c == CH_J) begin
                        for (int r = 0; r < urows(); r++)
                            for (int k = 0; k < ucols(); k++)
                                screen[r*TCE_MAX_COLS + k] = CH_SPACE;
                        cur_row = 0;
                        cur_col = 0;
                        mk_valid = 1'b0;
                        mk_row = 0;
                        mk_col = 0;
                        add_cmd(OP_CLEAR, 0, 0, 0, 1'b0);
                    end else if (c == CH_H) place_cursor();
                    pmode = PM_NORMAL;
                end
            end
        endcase
        if (byte_cmds.size() > 0) byte_cmds[byte_cmds.size()-1].last = 1'b1;
        foreach (byte_cmds[i]) expected_cmds.push_back(byte_cmds[i]);
    endtask

    task automatic report(string what, t_cmd_word got, t_cmd_word want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    // Sample the byte channel and check the result channel
    always @(posedge i_clk) begin
        t_cmd_word got, want;
        byte_taken <= bif.valid && bif.ready;
        if (i_rst_n) begin
            if (bif.valid && bif.ready) begin
                console_step(bif.ch);
                n_taken++;
            end
            if (cif.valid && cif.ready) begin
                got = {cif.op, cif.cell_row, cif.cell_col, cif.glyph_code,
                       cif.inverted, cif.last};
                if (expected_cmds.size() == 0) report("unexpected word", got, '0);
                else begin
                    want = expected_cmds.pop_front();
                    if (got.op != want.op) report("op", got, want);
                    else if (got.row != want.row) report("cell_row", got, want);
                    else if (got.col != want.col) report("cell_col", got, want);
                    else if (got.glyph != want.glyph) report("glyph_code", got, want);
                    else if (got.inv != want.inv) report("inverted", got, want);
                    else if (got.last != want.last) report("last", got, want);
                end
            end
        end
    end

    // Drive bytes and result stalls
    always @(negedge i_clk) begin
        steady <= (n_taken >= 500 && n_taken < 750);
        if (i_rst_n && (!bif.valid || byte_taken)) begin
            if (pending_bytes.size() > 0 && (steady || $urandom_range(99) >= 28)) begin
                bif.ch <= pending_bytes.pop_front();
                bif.valid <= 1'b1;
            end else bif.valid <= 1'b0;
        end
        cif.ready <= steady || ($urandom_range(99) >= 28);
    end

    task automatic push_num(int v);
        string s;
        s = $sformatf("%0d", v);
        for (int i = 0; i < s.len(); i++) pending_bytes.push_back(s[i]);
    endtask

    function automatic int pick_param(int span);
        int k;
        k = $urandom_range(99);
        if (k < 10) return 0;
        if (k < 18) return $urandom_range(999999, 60000);
        return $urandom_range(span + 2, 1);
    endfunction

    // Fill the byte queue with mostly well-formed text and sequences
    task automatic gen_text(int n, bit big);
        int goal, k, run, fin;
        goal = pending_bytes.size() + n;
        while (pending_bytes.size() < goal) begin
            k = $urandom_range(99);
            if (k < 48) begin
                run = $urandom_range(8, 1);
                repeat (run) pending_bytes.push_back(CH_W'($urandom_range(8'h7E, 8'h20)));
            end else if (k < 56) begin
                if (!big) pending_bytes.push_back(CH_NL);
            end else if (k < 61) pending_bytes.push_back(CH_CR);
            else if (k < 66) pending_bytes.push_back(CH_BS);
            else if (k < 86) begin
                pending_bytes.push_back(CH_ESC);
                pending_bytes.push_back(CH_LBR);
                if ($urandom_range(3) != 0) push_num(pick_param(urows()));
                if ($urandom_range(3) != 0) begin
                    pending_bytes.push_back(CH_SEMI);
                    if ($urandom_range(4) != 0) push_num(pick_param(ucols()));
                    if ($urandom_range(9) == 0) begin
                        pending_bytes.push_back(CH_SEMI);
                        push_num($urandom_range(9));
                    end
                end
                fin = $urandom_range(9);
                if (fin < 6) pending_bytes.push_back(CH_H);
                else if (fin < 8 && !big) pending_bytes.push_back(CH_J);
                else pending_bytes.push_back(CH_W'($urandom_range(8'h7E, 8'h40)));
            end else if (k < 92) begin
                // broken escape
                pending_bytes.push_back(CH_ESC);
                pending_bytes.push_back(CH_W'($urandom_range(255)));
            end else begin
                k = $urandom_range(255);
                if (!(big && (k == CH_NL || k == CH_J))) pending_bytes.push_back(CH_W'(k));
            end
        end
    endtask

    function automatic int settle_cycles();
        return 2 * urows() * ucols() + ucols() + 50;
    endfunction

    task automatic wait_quiet();
        while (pending_bytes.size() != 0 || bif.valid || expected_cmds.size() != 0)
            @(posedge i_clk);
        repeat (settle_cycles()) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IW-1:0] idx, int value);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = value[CFG_DW-1:0];
        if (idx == CFG_ENABLE) con_en = value[0];
        else if (idx == CFG_COLS) con_cols = value[CCFG_W-1:0];
        else if (idx == CFG_ROWS) con_rows = value[RCFG_W-1:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_geometry(int en, int cols, int rows);
        wait_quiet();
        cfg_write(CFG_COLS, cols);
        cfg_write(CFG_ROWS, rows);
        cfg_write(CFG_ENABLE, en);
    endtask

    task automatic push_csi(int a, int b, logic [CH_W-1:0] fin);
        pending_bytes.push_back(CH_ESC);
        pending_bytes.push_back(CH_LBR);
        push_num(a);
        pending_bytes.push_back(CH_SEMI);
        push_num(b);
        pending_bytes.push_back(fin);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_ENABLE;
        i_cfg_data = '0;
        bif.valid = 1'b0;
        bif.ch = '0;
        cif.ready = 1'b0;
        byte_taken = 1'b0;
        steady = 1'b0;
        n_errors = 0;
        n_taken = 0;
        con_en = 1'b0;
        con_cols = COLS_RST;
        con_rows = ROWS_RST;
        pmode = PM_NORMAL;
        pcount = 0;
        pval[0] = 0;
        pval[1] = 0;
        cur_row = 0;
        cur_col = 0;
        mk_valid = 1'b0;
        mk_row = 0;
        mk_col = 0;
        foreach (screen[i]) screen[i] = CH_SPACE;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // disabled after reset: bytes are ignored
        pending_bytes.push_back(8'h41);
        pending_bytes.push_back(CH_NL);
        pending_bytes.push_back(CH_ESC);
        wait_quiet();
        cfg_write(CFG_ENABLE, 1);

        // directed: field extremes, controls, escape corner cases
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(CH_BS);
        pending_bytes.push_back(CH_BS);
        pending_bytes.push_back(CH_BS);
        pending_bytes.push_back(CH_CR);
        pending_bytes.push_back(CH_NL);
        pending_bytes.push_back(CH_ESC);
        pending_bytes.push_back(8'h78);
        push_csi(3, 4, CH_H);
        pending_bytes.push_back(CH_ESC);
        pending_bytes.push_back(CH_LBR);
        pending_bytes.push_back(CH_SEMI);
        push_num(2);
        pending_bytes.push_back(CH_H);
        push_csi(99999, 1, CH_H);
        push_csi(1, 2, CH_SEMI);
        push_num(3);
        pending_bytes.push_back(CH_H);
        push_csi(2, 2, 8'h51);
        pending_bytes.push_back(CH_ESC);
        pending_bytes.push_back(CH_LBR);
        pending_bytes.push_back(CH_H);
        pending_bytes.push_back(CH_ESC);
        pending_bytes.push_back(CH_LBR);
        pending_bytes.push_back(CH_J);
        gen_text(250, 1'b0);

        // small and degenerate geometries
        set_geometry(1, 8, 4);
        gen_text(250, 1'b0);
        set_geometry(1, 1, 1);
        gen_text(120, 1'b0);
        set_geometry(1, 0, 0);
        gen_text(80, 1'b0);
        set_geometry(0, 5, 3);
        gen_text(40, 1'b0);
        set_geometry(1, 3, 2);
        gen_text(150, 1'b0);
        set_geometry(1, 17, 5);
        gen_text(200, 1'b0);

        // largest screen, values above the limits act as the limits
        set_geometry(1, 511, 255);
        push_csi(128, 256, CH_H);
        pending_bytes.push_back(8'h5A);
        gen_text(40, 1'b1);
        set_geometry(1, 256, 128);
        push_csi(128, 256, CH_H);
        gen_text(40, 1'b1);
        pending_bytes.push_back(CH_ESC);
        pending_bytes.push_back(CH_LBR);
        pending_bytes.push_back(CH_J);

        set_geometry(1, 40, 10);
        gen_text(250, 1'b0);

        wait_quiet();
        if (n_errors == 0 && expected_cmds.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

`default_nettype wire
